[hw/rtl/scm_pkg.sv]
// Shared types and constants for the sample counter continuity monitor.
package scm_pkg;

  localparam int CNT_W       = 32;
  localparam int SKIP_W      = 48;
  localparam int THR_W       = 19;
  localparam int T_W         = 24;
  localparam int RATE_W      = 16;
  localparam int LIM_W       = 42;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd975;
  localparam logic [THR_W-1:0]  THR_MIN    = 19'd10;
  localparam logic [CNT_W-1:0]  RUN_ERR    = 32'd50;
  localparam logic [CNT_W-1:0]  RUN_WARN   = 32'd10;
  localparam logic [17:0]       REP_ERR_BASE   = 18'd100;
  localparam logic [17:0]       REP_WARN_BASE  = 18'd60;
  localparam logic [17:0]       SKIP_ERR_BASE  = 18'd50;
  localparam logic [17:0]       SKIP_WARN_BASE = 18'd30;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_RATE   = 1'b1;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_REPORT  = 1'b1
  } scm_op_t;

  typedef enum logic [1:0] {
    LEVEL_OK    = 2'd0,
    LEVEL_WARN  = 2'd1,
    LEVEL_ERROR = 2'd2
  } scm_level_t;

  typedef struct packed {
    scm_op_t          op;
    logic [CNT_W-1:0] counter;
    logic [T_W-1:0]   t;
  } scm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scm_qstat_t;

endpackage

[hw/rtl/scm_front.sv]
// Front end: takes input items, classifies them and clamps the window length.
module scm_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     operation,
  input  logic [scm_pkg::CNT_W-1:0] counter_value,
  input  logic [scm_pkg::T_W-1:0]  elapsed_ms,
  input  scm_pkg::scm_qstat_t      qstat,
  output logic                     push,
  output scm_pkg::scm_item_t       item
);
  import scm_pkg::*;

  logic      hold_valid;
  scm_item_t hold;
  logic      accept;

  assign in_stall = hold_valid && qstat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = hold_valid && !qstat.full;
  assign item     = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.op      <= operation ? OP_REPORT : OP_OBSERVE;
      hold.counter <= counter_value;
      hold.t       <= (elapsed_ms == '0) ? T_W'(1) : elapsed_ms;
    end
  end

endmodule

[hw/rtl/scm_queue.sv]
// Short item queue between front end and back end.
module scm_queue #(
  parameter int DEPTH = scm_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scm_pkg::scm_item_t  item,
  input  logic                pop,
  output scm_pkg::scm_item_t  head,
  output scm_pkg::scm_qstat_t qstat
);
  import scm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  scm_item_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W_Q-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == CNT_W_Q'(DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W_Q'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W_Q'(1);
      end
    end
  end

endmodule

[hw/rtl/scm_back.sv]
// Back end: window statistics, threshold divider, limit multiplier, verdict.
module scm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [scm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scm_pkg::RATE_W-1:0]    cfg_data,
  input  scm_pkg::scm_qstat_t           qstat,
  input  scm_pkg::scm_item_t            head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    level,
  output logic [scm_pkg::CNT_W-1:0]     stale_reads,
  output logic [scm_pkg::SKIP_W-1:0]    lost_samples,
  output logic [scm_pkg::CNT_W-1:0]     jump_hits,
  output logic [scm_pkg::CNT_W-1:0]     max_step,
  output logic [scm_pkg::CNT_W-1:0]     repeat_run,
  output logic [scm_pkg::CNT_W-1:0]     longest_repeat_run,
  output logic [scm_pkg::THR_W-1:0]     jump_threshold
);
  import scm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EVAL = 4'b1000
  } scm_state_t;

  localparam logic [4:0] DIV_LAST = 5'(THR_W - 1);

  scm_state_t state;

  logic [RATE_W-1:0] sensor_rate;
  logic [RATE_W-1:0] read_rate;

  logic              have_last;
  logic [CNT_W-1:0]  last_counter;
  logic [CNT_W-1:0]  repeat_count;
  logic [CNT_W-1:0]  run_length;
  logic [CNT_W-1:0]  longest_run;
  logic [CNT_W-1:0]  largest_step;
  logic [CNT_W-1:0]  jump_count;
  logic [SKIP_W-1:0] skip_total;

  logic [T_W-1:0]    t_reg;
  logic [RATE_W-1:0] rd_eff;
  logic [RATE_W-1:0] e_rep;
  logic [RATE_W-1:0] e_skip;
  logic [THR_W-1:0]  div_num;
  logic [RATE_W-1:0] div_rem;
  logic [THR_W-1:0]  div_quo;
  logic [4:0]        div_cnt;
  logic [1:0]        mul_idx;
  logic [LIM_W-1:0]  lim [4];
  logic [LIM_W-1:0]  rep_scaled;
  logic [SKIP_W+9:0] skip_scaled;

  logic              observe_go;
  logic              report_go;
  logic              emit;
  logic [CNT_W-1:0]  step;
  logic [CNT_W-1:0]  run_inc;
  logic [SKIP_W:0]   skip_sum;
  logic [RATE_W-1:0] rd_now;
  logic [RATE_W:0]   div_trial;
  logic              div_bit;
  logic [17:0]       mul_op;
  logic [THR_W-1:0]  thr;
  logic [THR_W+2:0]  thr5;
  logic [CNT_W-1:0]  longest;
  logic              err;
  logic              warn;
  scm_level_t        level_next;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  assign observe_go = state == ST_IDLE && !qstat.empty && head.op == OP_OBSERVE;
  assign report_go  = state == ST_IDLE && !qstat.empty && head.op == OP_REPORT;
  assign pop        = state == ST_IDLE && !qstat.empty;
  assign emit       = state == ST_EVAL && (!out_valid || !out_stall);

  assign step     = head.counter - last_counter;
  assign run_inc  = inc_sat(run_length);
  assign skip_sum = {1'b0, skip_total} + (SKIP_W + 1)'(step - CNT_W'(1));
  assign rd_now   = (read_rate == '0) ? RATE_W'(1) : read_rate;

  assign div_trial = {div_rem, div_num[THR_W-1]};
  assign div_bit   = div_trial >= {1'b0, rd_eff};

  always_comb begin
    case (mul_idx)
      2'd0:    mul_op = {1'b0, e_rep, 1'b0} + REP_ERR_BASE;
      2'd1:    mul_op = {1'b0, e_rep, 1'b0} + REP_WARN_BASE;
      2'd2:    mul_op = {1'b0, e_skip, 1'b0} + SKIP_ERR_BASE;
      default: mul_op = {1'b0, e_skip, 1'b0} + SKIP_WARN_BASE;
    endcase
  end

  assign thr     = (div_quo < THR_MIN) ? THR_MIN : div_quo;
  assign thr5    = {thr, 2'b00} + {3'b000, thr};
  assign longest = (run_length > longest_run) ? run_length : longest_run;

  assign err = longest >= RUN_ERR || rep_scaled > lim[0] ||
               skip_scaled > {16'b0, lim[2]} ||
               largest_step > {10'b0, thr5};
  assign warn = longest >= RUN_WARN || rep_scaled > lim[1] ||
                skip_scaled > {16'b0, lim[3]} ||
                largest_step > {13'b0, thr};
  assign level_next = err ? LEVEL_ERROR : (warn ? LEVEL_WARN : LEVEL_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_rate <= RATE_RESET;
      read_rate   <= RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SENSOR_RATE: sensor_rate <= cfg_data;
        CFG_READ_RATE:   read_rate   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
      mul_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          div_cnt <= '0;
          mul_idx <= '0;
          if (report_go) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == DIV_LAST) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          mul_idx <= mul_idx + 2'd1;
          if (mul_idx == 2'd3) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (report_go) begin
      t_reg       <= head.t;
      rd_eff      <= rd_now;
      e_rep       <= (rd_now > sensor_rate) ? rd_now - sensor_rate : '0;
      e_skip      <= (sensor_rate > rd_now) ? sensor_rate - rd_now : '0;
      div_num     <= {1'b0, sensor_rate, 2'b00} + {3'b000, sensor_rate}
                     + {3'b000, rd_now} - THR_W'(1);
      div_rem     <= '0;
      div_quo     <= '0;
      rep_scaled  <= {repeat_count, 10'b0} - {6'b0, repeat_count, 4'b0}
                     - {7'b0, repeat_count, 3'b0};
      skip_scaled <= {skip_total, 10'b0} - {6'b0, skip_total, 4'b0}
                     - {7'b0, skip_total, 3'b0};
    end
    if (state == ST_DIV) begin
      div_num <= {div_num[THR_W-2:0], 1'b0};
      div_rem <= div_bit ? RATE_W'(div_trial - {1'b0, rd_eff}) : div_trial[RATE_W-1:0];
      div_quo <= {div_quo[THR_W-2:0], div_bit};
    end
    if (state == ST_MUL) begin
      lim[mul_idx] <= LIM_W'(mul_op) * LIM_W'(t_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last    <= 1'b0;
      last_counter <= '0;
      repeat_count <= '0;
      run_length   <= '0;
      longest_run  <= '0;
      largest_step <= '0;
      jump_count   <= '0;
      skip_total   <= '0;
    end else if (observe_go) begin
      have_last    <= 1'b1;
      last_counter <= head.counter;
      if (have_last) begin
        if (step == '0) begin
          repeat_count <= inc_sat(repeat_count);
          run_length   <= run_inc;
          if (run_inc > longest_run) begin
            longest_run <= run_inc;
          end
        end else begin
          run_length <= '0;
          if (step > largest_step) begin
            largest_step <= step;
          end
          if (step > CNT_W'(1)) begin
            jump_count <= inc_sat(jump_count);
            skip_total <= skip_sum[SKIP_W] ? '1 : skip_sum[SKIP_W-1:0];
          end
        end
      end
    end else if (emit) begin
      repeat_count <= '0;
      skip_total   <= '0;
      jump_count   <= '0;
      largest_step <= '0;
      longest_run  <= run_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      level              <= level_next;
      stale_reads        <= repeat_count;
      lost_samples       <= skip_total;
      jump_hits          <= jump_count;
      max_step           <= largest_step;
      repeat_run         <= run_length;
      longest_repeat_run <= longest;
      jump_threshold     <= thr;
    end
  end

endmodule

[hw/rtl/sample_counter_continuity_monitor.sv]
// Top level of the sample counter continuity monitor.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    operation, counter_value, elapsed_ms
//   out      output     out_valid / out_stall  level and window statistics
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// An observe item is handled in the idle state alone; a report passes setup,
// the one-bit-per-cycle threshold divider, the shared limit multiplier and the
// verdict. A front register and a two-entry queue sit ahead of the back end.
// Synchronous reset clears all control and statistics state.
// out_stall holds the result register; observes proceed, reports wait at the verdict.
module sample_counter_continuity_monitor #(
  parameter int QUEUE_DEPTH = scm_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [scm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scm_pkg::RATE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [scm_pkg::CNT_W-1:0]     counter_value,
  input  logic [scm_pkg::T_W-1:0]       elapsed_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    level,
  output logic [scm_pkg::CNT_W-1:0]     stale_reads,
  output logic [scm_pkg::SKIP_W-1:0]    lost_samples,
  output logic [scm_pkg::CNT_W-1:0]     jump_hits,
  output logic [scm_pkg::CNT_W-1:0]     max_step,
  output logic [scm_pkg::CNT_W-1:0]     repeat_run,
  output logic [scm_pkg::CNT_W-1:0]     longest_repeat_run,
  output logic [scm_pkg::THR_W-1:0]     jump_threshold
);
  import scm_pkg::*;

  scm_qstat_t qstat;
  scm_item_t  push_item;
  scm_item_t  head;
  logic       push;
  logic       pop;

  scm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .counter_value  (counter_value),
    .elapsed_ms     (elapsed_ms),
    .qstat          (qstat),
    .push           (push),
    .item           (push_item)
  );

  scm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (push_item),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  scm_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .qstat              (qstat),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .level              (level),
    .stale_reads        (stale_reads),
    .lost_samples       (lost_samples),
    .jump_hits          (jump_hits),
    .max_step           (max_step),
    .repeat_run         (repeat_run),
    .longest_repeat_run (longest_repeat_run),
    .jump_threshold     (jump_threshold)
  );

endmodule

[hw/rtl/scm_checker.sv]
// Port-level checks for the continuity monitor, bound to the top level.
module scm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    level,
  input logic [scm_pkg::SKIP_W-1:0]    lost_samples,
  input logic [scm_pkg::CNT_W-1:0]     repeat_run,
  input logic [scm_pkg::CNT_W-1:0]     longest_repeat_run,
  input logic [scm_pkg::THR_W-1:0]     jump_threshold
);
  import scm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) &&
      $stable(lost_samples) && $stable(jump_threshold))
    else $error("result changed while stalled");

  a_no_result_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

  a_longest: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> longest_repeat_run >= repeat_run)
    else $error("longest run below current run");

  a_thr_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> jump_threshold >= THR_MIN)
    else $error("jump threshold below minimum");

  a_run_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && longest_repeat_run >= RUN_ERR |-> level == LEVEL_ERROR)
    else $error("long repeat run not flagged as error");

endmodule

bind sample_counter_continuity_monitor scm_checker u_scm_checker (.*);

[bench/sample_counter_continuity_monitor_tb.sv]
// Testbench for the sample counter continuity monitor: random counter streams, scored reports.
`timescale 1ns / 1ps

module sample_counter_continuity_monitor_tb;
  import scm_pkg::*;

  typedef struct {
    scm_level_t       verdict;
    logic [CNT_W-1:0]  repeats;
    logic [SKIP_W-1:0] skipped;
    logic [CNT_W-1:0]  jumps;
    logic [CNT_W-1:0]  peak;
    logic [CNT_W-1:0]  run_cur;
    logic [CNT_W-1:0]  run_max;
    logic [THR_W-1:0]  thr;
  } window_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SENSOR_RATE;
  logic [RATE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 operation = OP_OBSERVE;
  logic [CNT_W-1:0]     counter_value = '0;
  logic [T_W-1:0]       elapsed_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           level;
  logic [CNT_W-1:0]     stale_reads;
  logic [SKIP_W-1:0]    lost_samples;
  logic [CNT_W-1:0]     jump_hits;
  logic [CNT_W-1:0]     max_step;
  logic [CNT_W-1:0]     repeat_run;
  logic [CNT_W-1:0]     longest_repeat_run;
  logic [THR_W-1:0]     jump_threshold;

  sample_counter_continuity_monitor dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .counter_value(counter_value),
    .elapsed_ms(elapsed_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .level(level),
    .stale_reads(stale_reads),
    .lost_samples(lost_samples),
    .jump_hits(jump_hits),
    .max_step(max_step),
    .repeat_run(repeat_run),
    .longest_repeat_run(longest_repeat_run),
    .jump_threshold(jump_threshold)
  );

  always #5 clk = ~clk;

  scm_item_t      pending[$];
  window_report_t expected_reports[$];
  int             mismatches = 0;

  // predictor copy of configuration and window state
  logic [RATE_W-1:0] sensor_hz = RATE_RESET;
  logic [RATE_W-1:0] read_hz = RATE_RESET;
  logic              seen_counter = 1'b0;
  logic [CNT_W-1:0]  prev_counter = '0;
  logic [CNT_W-1:0]  rep_total = '0;
  logic [CNT_W-1:0]  run_now = '0;
  logic [CNT_W-1:0]  run_best = '0;
  logic [CNT_W-1:0]  step_peak = '0;
  logic [CNT_W-1:0]  jump_total = '0;
  logic [SKIP_W-1:0] skip_sum = '0;

  logic [CNT_W-1:0]  stim_counter = '0;
  int unsigned       phase_items;
  int unsigned       in_gap = 0;
  int unsigned       in_calm = 0;
  int unsigned       out_hold = 0;
  int unsigned       out_calm = 0;

  function automatic void track_window(scm_op_t op, logic [CNT_W-1:0] cnt, logic [T_W-1:0] ms);
    logic [CNT_W-1:0] stepv;
    logic [SKIP_W:0]  sum49;
    longint unsigned  t, sens, rd, e_rep, e_skip, thr, longest, rs, ss, pk;
    logic             err, warn;
    window_report_t   rpt;
    if (op == OP_OBSERVE) begin
      if (!seen_counter) begin
        seen_counter = 1'b1;
      end else begin
        stepv = cnt - prev_counter;
        if (stepv == 0) begin
          if (rep_total != '1) rep_total++;
          if (run_now != '1) run_now++;
          if (run_now > run_best) run_best = run_now;
        end else begin
          run_now = '0;
          if (stepv > step_peak) step_peak = stepv;
          if (stepv > 1) begin
            if (jump_total != '1) jump_total++;
            sum49 = {1'b0, skip_sum} + {17'd0, stepv} - 49'd1;
            skip_sum = sum49[SKIP_W] ? '1 : sum49[SKIP_W-1:0];
          end
        end
      end
      prev_counter = cnt;
    end else begin
      t = (ms == 0) ? 1 : ms;
      sens = sensor_hz;
      rd = (read_hz == 0) ? 1 : read_hz;
      e_rep = (rd > sens) ? rd - sens : 0;
      e_skip = (sens > rd) ? sens - rd : 0;
      thr = (5 * sens + rd - 1) / rd;
      if (thr < 10) thr = 10;
      longest = (run_now > run_best) ? run_now : run_best;
      rs = rep_total;
      rs = rs * 1000;
      ss = skip_sum;
      ss = ss * 1000;
      pk = step_peak;
      err = longest >= 50 || rs > (2 * e_rep + 100) * t ||
            ss > (2 * e_skip + 50) * t || pk > thr * 5;
      warn = longest >= 10 || rs > (2 * e_rep + 60) * t ||
             ss > (2 * e_skip + 30) * t || pk > thr;
      rpt.verdict = err ? LEVEL_ERROR : (warn ? LEVEL_WARN : LEVEL_OK);
      rpt.repeats = rep_total;
      rpt.skipped = skip_sum;
      rpt.jumps   = jump_total;
      rpt.peak    = step_peak;
      rpt.run_cur = run_now;
      rpt.run_max = longest[CNT_W-1:0];
      rpt.thr     = thr[THR_W-1:0];
      expected_reports.push_back(rpt);
      rep_total  = '0;
      skip_sum   = '0;
      jump_total = '0;
      step_peak  = '0;
      run_best   = run_now;
    end
  endfunction

  // idle length for one item; occasional stretches with none at all
  function automatic int unsigned idle_cycles(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 50);
    return $urandom_range(0, 18);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    scm_item_t nxt;
    logic      hold;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      hold = in_valid;
      if (in_valid && !in_stall) begin
        track_window(scm_op_t'(operation), counter_value, elapsed_ms);
        hold = 1'b0;
        in_gap = idle_cycles(in_calm);
      end
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          operation <= nxt.op;
          counter_value <= nxt.counter;
          elapsed_ms <= nxt.t;
          hold = 1'b1;
        end
      end
      in_valid <= hold;
    end
  end

  // monitor; stall count runs down only while a report is offered
  always @(posedge clk) begin
    window_report_t want;
    int unsigned    hold_n;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      hold_n = out_hold;
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("report item with none expected");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("level", want.verdict, level);
          check_field("stale_reads", want.repeats, stale_reads);
          check_field("lost_samples", want.skipped, lost_samples);
          check_field("jump_hits", want.jumps, jump_hits);
          check_field("max_step", want.peak, max_step);
          check_field("repeat_run", want.run_cur, repeat_run);
          check_field("longest_repeat_run", want.run_max, longest_repeat_run);
          check_field("jump_threshold", want.thr, jump_threshold);
        end
        hold_n = idle_cycles(out_calm);
      end else if (out_valid && hold_n > 0) begin
        hold_n--;
      end
      out_hold = hold_n;
      out_stall <= (hold_n != 0);
    end
  end

  task automatic push_observe(logic [CNT_W-1:0] cnt);
    scm_item_t it;
    it.op = OP_OBSERVE;
    it.counter = cnt;
    it.t = T_W'($urandom);
    pending.push_back(it);
    stim_counter = cnt;
    phase_items++;
  endtask

  task automatic push_report(logic [T_W-1:0] ms);
    scm_item_t it;
    it.op = OP_REPORT;
    it.counter = $urandom;
    it.t = ms;
    pending.push_back(it);
    phase_items++;
  endtask

  task automatic queue_random_window();
    int unsigned n_obs;
    int unsigned kind;
    int unsigned run_len;
    logic [T_W-1:0] ms;
    n_obs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(4, 24);
    repeat (n_obs) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        push_observe(stim_counter + 1);
      end else if (kind < 72) begin
        run_len = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3);
        repeat (run_len) push_observe(stim_counter);
      end else if (kind < 88) begin
        push_observe(stim_counter + $urandom_range(2, 40));
      end else if (kind < 94) begin
        push_observe(stim_counter + $urandom);
      end else if (kind < 97) begin
        push_observe($urandom);
      end else begin
        push_observe(32'hFFFF_FFFF - $urandom_range(0, 20));
      end
    end
    case ($urandom_range(0, 5))
      0: ms = '0;
      1: ms = T_W'($urandom_range(1, 20));
      2: ms = T_W'($urandom_range(1, 300));
      3: ms = T_W'($urandom_range(300, 20000));
      4: ms = T_W'($urandom);
      default: ms = 24'hFF_FFFF - T_W'($urandom_range(0, 3));
    endcase
    push_report(ms);
  endtask

  // wait for the block to go idle; observes leave nothing to wait on
  task automatic drain_block();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_rates(logic [RATE_W-1:0] sens, logic [RATE_W-1:0] rd);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SENSOR_RATE;
    cfg_data <= sens;
    @(posedge clk);
    cfg_index <= CFG_READ_RATE;
    cfg_data <= rd;
    @(posedge clk);
    cfg_write <= 1'b0;
    sensor_hz = sens;
    read_hz = rd;
  endtask

  initial begin
    logic [RATE_W-1:0] sens_list [7];
    logic [RATE_W-1:0] read_list [7];
    sens_list = '{16'd65535, 16'd1, 16'd0, 16'd975, 16'd0, 16'd1000, 16'd65535};
    read_list = '{16'd1, 16'd65535, 16'd975, 16'd0, 16'd0, 16'd250, 16'd65535};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset rates: empty window, first read, wrap, huge jump, long repeat run
    push_report('0);
    push_observe('0);
    push_observe('0);
    push_observe(32'd1);
    push_observe(32'hFFFF_FFFF);
    push_observe(32'd2);
    push_report(24'hFF_FFFF);
    push_observe(32'hFFFF_FFFF);
    push_observe(32'hFFFF_FFFF);
    push_observe('0);
    push_report(24'd1);
    repeat (12) push_observe(stim_counter);
    push_report('0);

    phase_items = 0;
    while (phase_items < 138) queue_random_window();

    for (int p = 0; p < 10; p++) begin
      drain_block();
      if (p < 7) set_rates(sens_list[p], read_list[p]);
      else set_rates(RATE_W'($urandom_range(1, 65535)), RATE_W'($urandom_range(1, 65535)));
      phase_items = 0;
      while (phase_items < 138) queue_random_window();
    end

    drain_block();
    if (mismatches == 0) begin
      $display("sample_counter_continuity_monitor_tb passed");
    end else begin
      $display("sample_counter_continuity_monitor_tb failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("sample_counter_continuity_monitor_tb failed");
    $finish;
  end

endmodule
